>>> sv/circle_point_generator_top_assert.svh
// Assertion macros for the circle point generator.
// Both sample on clk and are off while rst_n is low.
`ifndef CIRCLE_POINT_GENERATOR_TOP_ASSERT_SVH
`define CIRCLE_POINT_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define CPG_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("cpg: same-cycle check failed");

// Next-cycle implication.
`define CPG_ASSERT_NXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("cpg: next-cycle check failed");

`endif

>>> sv/cpg_pkg.sv
`default_nettype none

package cpg_pkg;

  localparam int RAD_W   = 11;
  localparam int OFF_W   = 12;
  localparam int DEC_W   = 16;
  localparam int RSQ_W   = 22;
  localparam int CNT_W   = 3;
  localparam logic [CNT_W-1:0] LAST_REFL = 3'd7;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  // Octant reflection order within one outline step
  localparam logic [CNT_W-1:0] REFL_AB   = 3'd0;
  localparam logic [CNT_W-1:0] REFL_BA   = 3'd1;
  localparam logic [CNT_W-1:0] REFL_NAB  = 3'd2;
  localparam logic [CNT_W-1:0] REFL_NBA  = 3'd3;
  localparam logic [CNT_W-1:0] REFL_ANB  = 3'd4;
  localparam logic [CNT_W-1:0] REFL_BNA  = 3'd5;
  localparam logic [CNT_W-1:0] REFL_NANB = 3'd6;

  typedef struct packed {
    logic              mode;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic [RAD_W-1:0]  radius;
    logic              fill;
  } in_t;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic              plot;
    logic              last_of_run;
    logic              figure_done;
  } out_t;

  // One step's worth of work waiting to be emitted
  typedef struct packed {
    logic signed [15:0]      cx;
    logic signed [15:0]      cy;
    logic signed [OFF_W-1:0] a;    // offset_x, or dx when filling
    logic signed [OFF_W-1:0] b;    // offset_y, or dy when filling
    logic [RSQ_W-1:0]        rsq;
    logic                    fill;
    logic                    done;
  } burst_t;

endpackage

`default_nettype wire

>>> sv/cpg_emit.sv
`default_nettype none

module cpg_emit #(
  parameter int COORD_BITS = 16
) (
  input  wire cpg_pkg::burst_t           burst,
  input  wire logic [cpg_pkg::CNT_W-1:0] cnt,
  output cpg_pkg::out_t                  res
);

  localparam int SH = 32 - COORD_BITS;

  logic signed [cpg_pkg::OFF_W-1:0] na, nb, ox, oy;
  logic signed [31:0] sx, sy, wx, wy;
  logic signed [2*cpg_pkg::OFF_W-1:0] sqa, sqb;
  logic [2*cpg_pkg::OFF_W:0] d2;
  logic in_disc, last;

  assign na = -burst.a;
  assign nb = -burst.b;

  always_comb begin
    ox = burst.a;
    oy = burst.b;
    if (!burst.fill) begin
      case (cnt)
        cpg_pkg::REFL_AB:   begin ox = burst.a; oy = burst.b; end
        cpg_pkg::REFL_BA:   begin ox = burst.b; oy = burst.a; end
        cpg_pkg::REFL_NAB:  begin ox = na;      oy = burst.b; end
        cpg_pkg::REFL_NBA:  begin ox = nb;      oy = burst.a; end
        cpg_pkg::REFL_ANB:  begin ox = burst.a; oy = nb;      end
        cpg_pkg::REFL_BNA:  begin ox = burst.b; oy = na;      end
        cpg_pkg::REFL_NANB: begin ox = na;      oy = nb;      end
        default:            begin ox = nb;      oy = na;      end
      endcase
    end
  end

  // wrap to COORD_BITS, sign-extend back
  assign sx = 32'(burst.cx) + 32'(ox);
  assign sy = 32'(burst.cy) + 32'(oy);
  assign wx = (sx <<< SH) >>> SH;
  assign wy = (sy <<< SH) >>> SH;

  // inside test for the scan box
  assign sqa = burst.a * burst.a;
  assign sqb = burst.b * burst.b;
  assign d2  = {1'b0, sqa} + {1'b0, sqb};
  assign in_disc = d2 <= {{(2*cpg_pkg::OFF_W+1-cpg_pkg::RSQ_W){1'b0}}, burst.rsq};

  assign last = burst.fill || (cnt == cpg_pkg::LAST_REFL);

  assign res.point_x     = wx[15:0];
  assign res.point_y     = wy[15:0];
  assign res.plot        = burst.fill ? in_disc : 1'b1;
  assign res.last_of_run = last;
  assign res.figure_done = last && burst.done;

endmodule

`default_nettype wire

>>> sv/circle_point_generator_top.sv
// Midpoint circle point generator.
// Results go through the emit stage register, then the output register, to out_.
// Outline step: eight results, one reflection per cycle from the emit counter
// while out_ready allows; fill step: one result; start request: no result.
// Reset (rst_n low, synchronous): idle, figure state zeroed, no result pending.
`default_nettype none
`include "circle_point_generator_top_assert.svh"

module circle_point_generator_top #(
  parameter int COORD_BITS = 16,
  parameter int RADIUS_MAX = 2047
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire cpg_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output cpg_pkg::out_t       out_data
);

  localparam int RAD_W = cpg_pkg::RAD_W;
  localparam int OFF_W = cpg_pkg::OFF_W;
  localparam int DEC_W = cpg_pkg::DEC_W;
  localparam int RAD_TOP = (1 << RAD_W) - 1;
  // radius saturation limit, clipped to what the field can carry anyway
  localparam logic [RAD_W-1:0] RAD_SAT =
    RAD_W'((RADIUS_MAX > RAD_TOP) ? RAD_TOP : RADIUS_MAX);

  // ---------------------------------------------------------------
  // Figure state
  // ---------------------------------------------------------------
  logic                      active_r, active_nxt;
  logic                      fill_mode_r, fill_mode_nxt;
  logic signed [15:0]        cx_r, cx_nxt, cy_r, cy_nxt;
  logic [RAD_W-1:0]          radius_r, radius_nxt;
  logic [cpg_pkg::RSQ_W-1:0] rsq_r, rsq_nxt;
  logic signed [OFF_W-1:0]   offset_x_r, offset_x_nxt, offset_y_r, offset_y_nxt;
  logic signed [DEC_W-1:0]   decision_r, decision_nxt;
  logic [OFF_W-1:0]          col_r, col_nxt, row_r, row_nxt;

  // ---------------------------------------------------------------
  // Emit stage: holds one accepted step until all its results left
  // ---------------------------------------------------------------
  logic                      burst_valid_r, burst_valid_nxt;
  logic [cpg_pkg::CNT_W-1:0] burst_cnt_r, burst_cnt_nxt;
  cpg_pkg::burst_t           burst_r, burst_nxt;

  // output register
  logic                      out_valid_r;
  cpg_pkg::out_t             out_data_r, emit_res;

  logic in_acc, out_load, burst_fin, step_go;

  assign out_load  = burst_valid_r && (!out_valid_r || out_ready);
  assign burst_fin = out_load && (burst_r.fill || burst_cnt_r == cpg_pkg::LAST_REFL);
  // free emit stage, or its last result leaves this cycle
  assign in_ready  = !burst_valid_r || burst_fin;
  assign in_acc    = in_valid && in_ready;
  assign step_go   = in_acc && (in_data.mode == cpg_pkg::MODE_STEP) && active_r;

  // ---------------------------------------------------------------
  // Per-request arithmetic
  // ---------------------------------------------------------------
  logic [RAD_W-1:0]        r_in;
  logic signed [OFF_W-1:0] nx, ny;
  logic signed [DEC_W-1:0] nd;
  logic                    ol_done;
  logic [OFF_W:0]          dx_w, dy_w;
  logic [OFF_W-1:0]        two_r, row_inc, col_inc;
  logic                    row_wrap, col_wrap;

  assign r_in = (in_data.radius > RAD_SAT) ? RAD_SAT : in_data.radius;

  // midpoint decision update
  always_comb begin
    nx = offset_x_r + OFF_W'(1);
    if (decision_r <= 0) begin
      ny = offset_y_r;
      nd = decision_r + (DEC_W'(nx) <<< 1) + DEC_W'(1);
    end else begin
      ny = offset_y_r - OFF_W'(1);
      nd = decision_r + (DEC_W'(nx - ny) <<< 1) + DEC_W'(1);
    end
  end
  assign ol_done = ny < nx;

  // scan box: dx = r - column, dy = r - row
  assign two_r    = {radius_r, 1'b0};
  assign dx_w     = {2'b00, radius_r} - {1'b0, col_r};
  assign dy_w     = {2'b00, radius_r} - {1'b0, row_r};
  assign row_inc  = row_r + OFF_W'(1);
  assign col_inc  = col_r + OFF_W'(1);
  assign row_wrap = row_inc >= two_r;
  assign col_wrap = col_inc >= two_r;

  always_comb begin
    active_nxt    = active_r;
    fill_mode_nxt = fill_mode_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    radius_nxt    = radius_r;
    rsq_nxt       = rsq_r;
    offset_x_nxt  = offset_x_r;
    offset_y_nxt  = offset_y_r;
    decision_nxt  = decision_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    burst_nxt     = burst_r;

    if (in_acc && in_data.mode == cpg_pkg::MODE_START) begin
      // new figure; any running one is dropped
      cx_nxt        = in_data.center_x;
      cy_nxt        = in_data.center_y;
      radius_nxt    = r_in;
      rsq_nxt       = r_in * r_in;
      fill_mode_nxt = in_data.fill;
      offset_x_nxt  = '0;
      offset_y_nxt  = $signed({1'b0, r_in});
      decision_nxt  = DEC_W'(1) - $signed(DEC_W'(r_in));
      col_nxt       = '0;
      row_nxt       = '0;
      active_nxt    = in_data.fill ? (r_in != '0) : 1'b1;
    end else if (step_go) begin
      burst_nxt.cx   = cx_r;
      burst_nxt.cy   = cy_r;
      burst_nxt.rsq  = rsq_r;
      burst_nxt.fill = fill_mode_r;
      if (!fill_mode_r) begin
        burst_nxt.a    = offset_x_r;
        burst_nxt.b    = offset_y_r;
        burst_nxt.done = ol_done;
        offset_x_nxt   = nx;
        offset_y_nxt   = ny;
        decision_nxt   = nd;
        if (ol_done) begin
          active_nxt = 1'b0;
        end
      end else begin
        burst_nxt.a    = dx_w[OFF_W-1:0];
        burst_nxt.b    = dy_w[OFF_W-1:0];
        burst_nxt.done = row_wrap && col_wrap;
        row_nxt        = row_wrap ? '0 : row_inc;
        if (row_wrap) begin
          col_nxt = col_wrap ? '0 : col_inc;
          if (col_wrap) begin
            active_nxt = 1'b0;
          end
        end
      end
    end
  end

  // emit stage control
  always_comb begin
    burst_valid_nxt = burst_valid_r;
    burst_cnt_nxt   = burst_cnt_r;
    if (step_go) begin
      burst_valid_nxt = 1'b1;
      burst_cnt_nxt   = '0;
    end else if (burst_fin) begin
      burst_valid_nxt = 1'b0;
    end else if (out_load) begin
      burst_cnt_nxt = burst_cnt_r + cpg_pkg::CNT_W'(1);
    end
  end

  cpg_emit #(
    .COORD_BITS (COORD_BITS)
  ) u_emit (
    .burst (burst_r),
    .cnt   (burst_cnt_r),
    .res   (emit_res)
  );

  // ---------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r      <= 1'b0;
      fill_mode_r   <= 1'b0;
      cx_r          <= '0;
      cy_r          <= '0;
      radius_r      <= '0;
      rsq_r         <= '0;
      offset_x_r    <= '0;
      offset_y_r    <= '0;
      decision_r    <= '0;
      col_r         <= '0;
      row_r         <= '0;
      burst_valid_r <= 1'b0;
      burst_cnt_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      active_r      <= active_nxt;
      fill_mode_r   <= fill_mode_nxt;
      cx_r          <= cx_nxt;
      cy_r          <= cy_nxt;
      radius_r      <= radius_nxt;
      rsq_r         <= rsq_nxt;
      offset_x_r    <= offset_x_nxt;
      offset_y_r    <= offset_y_nxt;
      decision_r    <= decision_nxt;
      col_r         <= col_nxt;
      row_r         <= row_nxt;
      burst_valid_r <= burst_valid_nxt;
      burst_cnt_r   <= burst_cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    burst_r <= burst_nxt;
    if (out_load) begin
      out_data_r <= emit_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  // a fill step always finishes in one result
  `CPG_ASSERT_IMP(a_fill_single, burst_valid_r && burst_r.fill, burst_cnt_r == '0)
  // an active fill never has a zero radius
  `CPG_ASSERT_IMP(a_fill_radius, active_r && fill_mode_r, radius_r != '0)
  // a pending step whose result is blocked keeps its place
  `CPG_ASSERT_NXT(a_burst_hold, burst_valid_r && !out_load,
                  burst_valid_r && $stable(burst_cnt_r))

endmodule

`default_nettype wire

>>> tb/cpg_check_pkg.sv
package cpg_check_pkg;
  import cpg_pkg::*;

  localparam int RADIUS_LIMIT = 2047;

  // Follows the figure state request by request and queues the points due out.
  class circle_figure_checker;
    bit                 live;
    bit                 filling;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    int                 rad;
    int                 ox;
    int                 oy;
    int                 dec;
    int                 col;
    int                 row;
    out_t               expected_points[$];
    int                 fail_count;
    int                 points_checked;
    int                 figures_done;
    int                 requests_seen;
    int                 starts_seen;

    function new();
      cx = '0;
      cy = '0;
    endfunction

    function bit figure_live();
      return live;
    endfunction

    function int outstanding();
      return expected_points.size();
    endfunction

    // Coordinates wrap at 16 bits.
    function logic signed [15:0] place(logic signed [15:0] base, int off);
      return base + 16'(off);
    endfunction

    function void queue_point(int dx, int dy, bit plot, bit last, bit done);
      out_t p;
      p.point_x     = place(cx, dx);
      p.point_y     = place(cy, dy);
      p.plot        = plot;
      p.last_of_run = last;
      p.figure_done = done;
      expected_points.push_back(p);
    endfunction

    function void note_request(in_t req);
      int a;
      int b;
      int dx;
      int dy;
      bit done;
      requests_seen++;
      if (req.mode == MODE_START) begin
        starts_seen++;
        rad = int'(req.radius);
        if (rad > RADIUS_LIMIT) rad = RADIUS_LIMIT;
        cx      = req.center_x;
        cy      = req.center_y;
        filling = req.fill;
        ox      = 0;
        oy      = rad;
        dec     = 1 - rad;
        col     = 0;
        row     = 0;
        live    = filling ? (rad != 0) : 1'b1;
        return;
      end
      if (!live) return;
      if (!filling) begin
        a  = ox;
        b  = oy;
        ox = a + 1;
        if (dec <= 0) begin
          dec += 2 * ox + 1;
        end else begin
          oy = b - 1;
          dec += 2 * (ox - oy) + 1;
        end
        done = oy < ox;
        queue_point( a,  b, 1, 0, 0);
        queue_point( b,  a, 1, 0, 0);
        queue_point(-a,  b, 1, 0, 0);
        queue_point(-b,  a, 1, 0, 0);
        queue_point( a, -b, 1, 0, 0);
        queue_point( b, -a, 1, 0, 0);
        queue_point(-a, -b, 1, 0, 0);
        queue_point(-b, -a, 1, 1, done);
        if (done) live = 0;
      end else begin
        dx   = rad - col;
        dy   = rad - row;
        done = 0;
        row++;
        if (row >= 2 * rad) begin
          row = 0;
          col++;
          if (col >= 2 * rad) begin
            col  = 0;
            done = 1;
            live = 0;
          end
        end
        queue_point(dx, dy, (dx * dx + dy * dy) <= rad * rad, 1, done);
      end
    endfunction

    task report(string msg);
      fail_count++;
      $display("mismatch: %s", msg);
    endtask

    task check_point(out_t got);
      out_t want;
      if (expected_points.size() == 0) begin
        report($sformatf("point (%0d,%0d) with none due", got.point_x, got.point_y));
        return;
      end
      want = expected_points.pop_front();
      points_checked++;
      if (got.figure_done) figures_done++;
      if (got.point_x !== want.point_x)
        report($sformatf("point %0d: x %0d, want %0d", points_checked, got.point_x,
                         want.point_x));
      if (got.point_y !== want.point_y)
        report($sformatf("point %0d: y %0d, want %0d", points_checked, got.point_y,
                         want.point_y));
      if (got.plot !== want.plot)
        report($sformatf("point %0d: plot %b, want %b", points_checked, got.plot, want.plot));
      if (got.last_of_run !== want.last_of_run)
        report($sformatf("point %0d: last_of_run %b, want %b", points_checked,
                         got.last_of_run, want.last_of_run));
      if (got.figure_done !== want.figure_done)
        report($sformatf("point %0d: figure_done %b, want %b", points_checked,
                         got.figure_done, want.figure_done));
    endtask

    task finish_check();
      if (expected_points.size() != 0)
        report($sformatf("%0d points never came out", expected_points.size()));
    endtask
  endclass

endpackage

>>> tb/circle_point_generator_top_test.sv
module circle_point_generator_top_test;
  import cpg_pkg::*;
  import cpg_check_pkg::*;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // steady: no idling on either side; hold_ask: receiver should go quiet for a while
  bit steady   = 1'b0;
  bit hold_ask = 1'b0;
  int counted  = 0;   // requests that start or advance a figure

  circle_figure_checker fig;

  circle_point_generator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Request building
  // ---------------------------------------------------------------------------
  function automatic in_t start_req(logic signed [15:0] x, logic signed [15:0] y,
                                    int r, bit f);
    in_t req;
    req.mode     = MODE_START;
    req.center_x = x;
    req.center_y = y;
    req.radius   = RAD_W'(r);
    req.fill     = f;
    return req;
  endfunction

  // Step requests carry junk in the unused fields so that every bit toggles.
  function automatic in_t step_req();
    in_t req;
    req.mode     = MODE_STEP;
    req.center_x = 16'($urandom);
    req.center_y = 16'($urandom);
    req.radius   = RAD_W'($urandom);
    req.fill     = 1'($urandom);
    return req;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Random gap after a request; geometric, so runs of idle cycles occur too.
  task automatic sender_pause();
    if (!steady)
      while ($urandom_range(99) < 19) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
  endtask

  // Offer one request and hold it until taken. The predictor is updated at
  // the accepting edge, so the caller sees the figure state the block has.
  task automatic send_request(in_t req);
    if (req.mode == MODE_START || fig.figure_live()) counted++;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    fig.note_request(req);
    sender_pause();
  endtask

  // Sender goes quiet until every predicted point has been taken.
  task automatic drain_results();
    if (fig.outstanding() != 0) begin
      in_valid <= 1'b0;
      while (fig.outstanding() != 0) @(posedge clk);
    end
  endtask

  // Step the current figure until it ends or the budget runs out.
  task automatic run_steps(int most);
    while (fig.figure_live() && most > 0) begin
      send_request(step_req());
      most--;
    end
  endtask

  // One figure with random content. Mostly run to completion; large radii
  // and a share of the rest are cut short by the next start request.
  task automatic random_figure(int serial);
    logic signed [15:0] x;
    logic signed [15:0] y;
    bit                 f;
    int                 r;
    int                 reach;
    if (serial % 5 == 4) drain_results();
    x = 16'($urandom);
    y = 16'($urandom);
    // centres close to the wrap point now and then
    if ($urandom_range(4) == 0) x = 16'sh7FF0 + 16'($urandom_range(31));
    if ($urandom_range(4) == 0) y = 16'sh7FF0 + 16'($urandom_range(31));
    f = ($urandom_range(99) < 35);
    if (f)
      r = $urandom_range(3);
    else if ($urandom_range(7) == 0)
      r = $urandom_range(2047);
    else
      r = $urandom_range(24);
    reach = (r > 24 || $urandom_range(3) == 0) ? $urandom_range(1, 6) : 1 << 30;
    send_request(start_req(x, y, r, f));
    run_steps(reach);
    // stray step: ignored when idle, otherwise one more step of a cut figure
    if ($urandom_range(9) == 0) send_request(step_req());
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int base;
    int serial;
    fig = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part.
    send_request(step_req());                                // step while idle
    send_request(start_req(16'sh0000, 16'sh0000, 0, 1'b0));  // outline, radius zero
    run_steps(4);                                            // centre eight times
    send_request(step_req());                                // idle again
    send_request(start_req(16'sh7FFF, 16'sh8000, 3, 1'b0));  // wraps both ways
    run_steps(10);
    send_request(start_req(16'sh1234, 16'sh4321, 0, 1'b1));  // fill, radius zero
    send_request(step_req());                                // must stay silent
    drain_results();
    send_request(start_req(16'sh8000, 16'sh7FFF, 1, 1'b1));  // smallest fill
    run_steps(10);
    // Receiver stalls for a long stretch under a large outline; the block
    // backs up and must hold its input off.
    hold_ask = 1'b1;
    send_request(start_req(16'sh5555, 16'shAAAA, 2047, 1'b0));
    run_steps(3);
    send_request(start_req(16'shFFFF, 16'shFFFF, 2047, 1'b1));  // abandons the outline
    run_steps(2);
    send_request(start_req(16'sh0100, 16'shFF00, 1, 1'b0));     // abandons the fill
    run_steps(10);

    // Random part, with a calm stretch in the middle.
    base   = counted;
    serial = 0;
    while (counted - base < 80) begin
      steady = (counted - base >= 30) && (counted - base < 60);
      random_figure(serial);
      serial++;
    end
    steady = 1'b0;

    // Wind down: everything predicted must come out, then nothing more.
    in_valid <= 1'b0;
    while (fig.outstanding() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    fig.finish_check();

    $display("Ran %0d requests (%0d starts), checked %0d points,", fig.requests_seen,
             fig.starts_seen, fig.points_checked);
    $display("with %0d figures traced or filled to their end.", fig.figures_done);
    if (fig.fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: checks every taken point, stalls at random, and on request
  // holds off for a long counted stretch.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int hold_cycles;
    hold_cycles = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) fig.check_point(out_data);
      if (hold_ask && hold_cycles == 0) begin
        hold_ask    = 1'b0;
        hold_cycles = 400;
      end
      out_ready <= (hold_cycles == 0) && (steady || $urandom_range(99) >= 19);
      if (hold_cycles > 0) hold_cycles--;
    end
  end

endmodule

>>> files.f
+incdir+sv
sv/cpg_pkg.sv
sv/cpg_emit.sv
sv/circle_point_generator_top.sv
tb/cpg_check_pkg.sv
tb/circle_point_generator_top_test.sv
